### design/hbd_pkg.sv
// Package for the Huffman tree bit decoder: table size, counter width,
// opcode codes, walk states, node record and result record. No dependencies.
`timescale 1ns / 1ps

package hbd_pkg;

	localparam int TREE_NODES = 512;
	localparam int NODE_W     = $clog2(TREE_NODES);
	localparam int COUNT_BITS = 24;
	localparam int CHILD_W    = 9;
	localparam int SYM_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int NBITS_W    = 4;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DATA = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH,
		ST_STATUS
	} walk_state_t;

	// One table entry.
	typedef struct packed {
		logic [CHILD_W-1:0] zero_child;
		logic [CHILD_W-1:0] one_child;
		logic               is_leaf;
		logic [SYM_W-1:0]   sym;
	} node_t;

	// One result word as it leaves the walker.
	typedef struct packed {
		logic [SYM_W-1:0]      symbol;
		logic                  symbol_valid;
		logic                  last;
		logic                  stream_done;
		logic                  incomplete_tail;
		logic [COUNT_BITS-1:0] symbols_so_far;
	} result_t;

endpackage

### design/hbd_node_mem.sv
// Node table of the Huffman tree bit decoder: one write port, one read port
// with registered read data, and a register copy of the root entry. Uses hbd_pkg.
`timescale 1ns / 1ps

module hbd_node_mem (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [hbd_pkg::NODE_W-1:0] wr_addr,
	input  hbd_pkg::node_t            wr_node,
	input  logic                      rd_en,
	input  logic [hbd_pkg::NODE_W-1:0] rd_addr,
	output hbd_pkg::node_t            rd_node,
	output hbd_pkg::node_t            root_node
);

	hbd_pkg::node_t mem [hbd_pkg::TREE_NODES];
	hbd_pkg::node_t rd_node_q;
	hbd_pkg::node_t root_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_node;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_node_q <= mem[rd_addr];
		end
	end

	// The root is kept beside the memory so that a step from the root needs no read.
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == '0) begin
			root_q <= wr_node;
		end
	end

	assign rd_node   = rd_node_q;
	assign root_node = root_q;

endmodule

### design/hbd_walker.sv
// Bit-serial tree walker: shifts the data byte out one bit a cycle unless
// stalled, steps through the node table and forms symbol and status results. Uses hbd_pkg.
`timescale 1ns / 1ps

module hbd_walker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hbd_pkg::BYTE_W-1:0]  data_byte,
	input  logic [hbd_pkg::NBITS_W-1:0] valid_bits,
	input  logic                        end_of_stream,
	input  hbd_pkg::node_t              rd_node,
	input  hbd_pkg::node_t              root_node,
	input  logic                        out_free,
	output logic                        busy,
	output logic                        rd_en,
	output logic [hbd_pkg::NODE_W-1:0]  rd_addr,
	output logic                        push,
	output hbd_pkg::result_t            result
);

	hbd_pkg::walk_state_t state_q, state_d;

	logic [hbd_pkg::BYTE_W-1:0]     shift_q;
	logic [hbd_pkg::NBITS_W-1:0]    cnt_q;
	logic                           eos_q;
	logic                           pend_q;
	logic                           at_root_q;
	logic [hbd_pkg::NODE_W-1:0]     addr_q;
	logic [hbd_pkg::COUNT_BITS-1:0] total_q;
	logic                           hold_v_q;
	hbd_pkg::result_t               hold_q;

	logic                           leaf_hit;
	logic                           at_root;
	hbd_pkg::node_t                 cur_node;
	logic                           bits_left;
	logic                           stall;
	logic                           step;
	logic [hbd_pkg::CHILD_W-1:0]    child_raw;
	logic [hbd_pkg::NODE_W-1:0]     next_addr;
	logic [hbd_pkg::COUNT_BITS-1:0] total_inc;
	logic [hbd_pkg::NBITS_W-1:0]    nbits_clip;
	logic                           walking;
	hbd_pkg::result_t               sym_res;

	// A pending read holds the node reached by the previous bit.
	assign walking   = (state_q == hbd_pkg::ST_WALK);
	assign leaf_hit  = walking && pend_q && rd_node.is_leaf;
	assign at_root   = pend_q ? leaf_hit : at_root_q;
	assign cur_node  = at_root ? root_node : rd_node;
	assign bits_left = (cnt_q != '0);
	// A new symbol can only be taken into the hold register if the one
	// already held can leave.
	assign stall     = leaf_hit && hold_v_q && !out_free;
	assign step      = walking && bits_left && !stall;
	assign child_raw = shift_q[0] ? cur_node.one_child : cur_node.zero_child;
	assign next_addr = (int'(child_raw) < hbd_pkg::TREE_NODES) ?
		hbd_pkg::NODE_W'(child_raw) : '0;
	assign total_inc = (total_q == '1) ? total_q : total_q + 1'b1;
	assign nbits_clip = (valid_bits > hbd_pkg::NBITS_W'(hbd_pkg::BYTE_W)) ?
		hbd_pkg::NBITS_W'(hbd_pkg::BYTE_W) : valid_bits;

	// A new byte re-reads the current node, since loads may have changed it.
	assign rd_en   = (start && !at_root_q) || step;
	assign rd_addr = start ? addr_q : next_addr;
	assign busy    = (state_q != hbd_pkg::ST_IDLE);

	// Symbol word for the leaf just reached; its last flag is settled later.
	always_comb begin
		sym_res                = '0;
		sym_res.symbol         = rd_node.sym;
		sym_res.symbol_valid   = 1'b1;
		sym_res.symbols_so_far = total_inc;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hbd_pkg::ST_IDLE: begin
				if (start) begin
					state_d = hbd_pkg::ST_WALK;
				end
			end
			hbd_pkg::ST_WALK: begin
				if (!bits_left && !stall) begin
					if (leaf_hit || hold_v_q) begin
						state_d = hbd_pkg::ST_FLUSH;
					end else begin
						state_d = eos_q ? hbd_pkg::ST_STATUS : hbd_pkg::ST_IDLE;
					end
				end
			end
			hbd_pkg::ST_FLUSH: begin
				if (out_free) begin
					state_d = eos_q ? hbd_pkg::ST_STATUS : hbd_pkg::ST_IDLE;
				end
			end
			hbd_pkg::ST_STATUS: begin
				if (out_free) begin
					state_d = hbd_pkg::ST_IDLE;
				end
			end
			default: state_d = hbd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		push   = 1'b0;
		result = '0;
		unique case (state_q)
			hbd_pkg::ST_WALK: begin
				// A second symbol shows that the held one is not the last.
				push   = leaf_hit && hold_v_q && out_free;
				result = hold_q;
			end
			hbd_pkg::ST_FLUSH: begin
				push        = out_free;
				result      = hold_q;
				result.last = !eos_q;
			end
			hbd_pkg::ST_STATUS: begin
				push                   = out_free;
				result.last            = 1'b1;
				result.stream_done     = 1'b1;
				result.incomplete_tail = !at_root_q && (addr_q != '0);
				result.symbols_so_far  = total_q;
			end
			default: begin
				push   = 1'b0;
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hbd_pkg::ST_IDLE;
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			at_root_q <= 1'b1;
			addr_q    <= '0;
			total_q   <= '0;
			hold_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				cnt_q  <= nbits_clip;
				pend_q <= 1'b0;
			end else if (walking && !stall) begin
				pend_q    <= step;
				at_root_q <= at_root;
				if (step) begin
					cnt_q  <= cnt_q - 1'b1;
					addr_q <= next_addr;
				end
				if (leaf_hit) begin
					total_q  <= total_inc;
					hold_v_q <= 1'b1;
				end
			end else if (state_q == hbd_pkg::ST_STATUS && out_free) begin
				at_root_q <= 1'b1;
				addr_q    <= '0;
				total_q   <= '0;
			end else if (state_q == hbd_pkg::ST_FLUSH && out_free) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= data_byte;
			eos_q   <= end_of_stream;
		end else if (step) begin
			shift_q <= shift_q >> 1;
		end
		if (leaf_hit && !stall) begin
			hold_q <= sym_res;
		end
	end

endmodule

### design/huffman_tree_bit_decoder.sv
// Top level of the Huffman tree bit decoder: stream ports, node loads,
// output register. Uses hbd_pkg, hbd_node_mem and hbd_walker.
//
//   Channel   Direction  Carries
//   s_axis    in         node load word or data byte word (tuser = opcode)
//   m_axis    out        decoded symbol word or end-of-stream status word
//
// A data byte word walks valid_bits bits (valid_bits clipped to 8), one node
// memory read per bit. Each symbol word is held back until a further symbol
// or the end of the byte shows whether it is the byte's last, so a byte that
// yields any symbol ends by sending the held word, and a byte marked as end of
// stream then sends the status word as well.
// The single read port of the node table paces the walk: each bit steps
// from the current node to a child whose entry is read from the table.
// Reset clears the walk position, the symbol count, the held symbol and the
// output register; the node table is undefined until written. When the
// output register is full and not taken, the walk halts on a leaf while an
// earlier symbol word still waits, and the sending of the held word and of
// the status word waits likewise; all resume when the register drains.
`timescale 1ns / 1ps

module huffman_tree_bit_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// From bit 0: node_index[9], zero_child[9], one_child[9], node_is_leaf,
	// node_symbol[8], data_byte[8], valid_bits[4].
	input  logic [47:0] s_axis_tdata,
	// Bit 0: opcode.
	input  logic        s_axis_tuser,
	// end_of_stream.
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// From bit 0: symbol[8], incomplete_tail, symbols_so_far[24], zero padding.
	output logic [39:0] m_axis_tdata,
	// From bit 0: symbol_valid, stream_done.
	output logic [1:0]  m_axis_tuser,
	// last.
	output logic        m_axis_tlast
);

	logic                          in_acc;
	logic                          is_data;
	logic                          wr_en;
	hbd_pkg::node_t                wr_node;
	logic [hbd_pkg::CHILD_W-1:0]   node_index;
	logic                          busy;
	logic                          rd_en;
	logic [hbd_pkg::NODE_W-1:0]    rd_addr;
	hbd_pkg::node_t                rd_node;
	hbd_pkg::node_t                root_node;
	logic                          out_free;
	logic                          push;
	hbd_pkg::result_t              result;
	logic                          out_valid_q;
	hbd_pkg::result_t              out_q;

	// Words are taken whenever the walker is idle; loads go straight to the table.
	assign s_axis_tready = !busy;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign is_data       = (hbd_pkg::opcode_t'(s_axis_tuser) == hbd_pkg::OP_DATA);

	assign node_index         = s_axis_tdata[8:0];
	assign wr_node.zero_child = s_axis_tdata[17:9];
	assign wr_node.one_child  = s_axis_tdata[26:18];
	assign wr_node.is_leaf    = s_axis_tdata[27];
	assign wr_node.sym        = s_axis_tdata[35:28];

	// A load beyond the table is dropped.
	assign wr_en = in_acc && !is_data && (int'(node_index) < hbd_pkg::TREE_NODES);

	hbd_node_mem u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (hbd_pkg::NODE_W'(node_index)),
		.wr_node   (wr_node),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_node   (rd_node),
		.root_node (root_node)
	);

	hbd_walker u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_acc && is_data),
		.data_byte     (s_axis_tdata[43:36]),
		.valid_bits    (s_axis_tdata[47:44]),
		.end_of_stream (s_axis_tlast),
		.rd_node       (rd_node),
		.root_node     (root_node),
		.out_free      (out_free),
		.busy          (busy),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.push          (push),
		.result        (result)
	);

	// The output register takes a new word in the same cycle as the old one leaves.
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q.symbols_so_far, out_q.incomplete_tail, out_q.symbol};
	assign m_axis_tuser  = {out_q.stream_done, out_q.symbol_valid};
	assign m_axis_tlast  = out_q.last;

endmodule

### bench/huffman_tree_bit_decoder_test.sv
// Self-checking bench for the Huffman tree bit decoder: random trees, streams
// and stalls on both stream ports, results predicted word by word.
// Depends on hbd_pkg and the huffman_tree_bit_decoder RTL.
`timescale 1ns / 1ps

module huffman_tree_bit_decoder_test;

	localparam int RANDOM_WORDS    = 200;
	localparam int PRESSURE_AT     = 60;    // result words taken before the long hold-off
	localparam int PRESSURE_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no handshake on either port
	localparam int DRAIN_CYCLES    = 32;

	// One input word in field form, before packing onto the slave port.
	typedef struct {
		hbd_pkg::opcode_t op;
		logic [8:0]       idx;
		logic [8:0]       zc;
		logic [8:0]       oc;
		logic             leaf;
		logic [7:0]       sym;
		logic [7:0]       dbyte;
		logic [3:0]       nbits;
		logic             eos;
	} dec_word_t;

	// Keeps its own copy of the node table and walk position, turns every
	// accepted input word into the result words it must cause, and matches
	// the words leaving the block against them in order.
	class symbol_scoreboard;
		hbd_pkg::node_t   node_table [hbd_pkg::TREE_NODES];
		logic [8:0]       walk_pos;
		logic [23:0]      stream_count;
		hbd_pkg::result_t symbols_due [$];
		int               mismatches;
		int               words_checked;

		function new();
			walk_pos      = '0;
			stream_count  = '0;
			mismatches    = 0;
			words_checked = 0;
		endfunction

		function int pending();
			return symbols_due.size();
		endfunction

		function void note_word(dec_word_t w);
			int               nb;
			int               made;
			logic [8:0]       nxt;
			hbd_pkg::node_t   cur;
			hbd_pkg::result_t r;
			made = 0;
			if (w.op == hbd_pkg::OP_LOAD) begin
				if (w.idx < hbd_pkg::TREE_NODES)
					node_table[w.idx] = '{w.zc, w.oc, w.leaf, w.sym};
				return;
			end
			nb = (w.nbits > 8) ? 8 : int'(w.nbits);
			for (int b = 0; b < nb; b++) begin
				cur = node_table[walk_pos];
				nxt = w.dbyte[b] ? cur.one_child : cur.zero_child;
				if (nxt >= hbd_pkg::TREE_NODES)
					nxt = '0;
				walk_pos = nxt;
				// The leaf test applies to the node just reached, the root included.
				if (node_table[nxt].is_leaf) begin
					if (stream_count != '1)
						stream_count++;
					r = '{symbol: node_table[nxt].sym, symbol_valid: 1'b1, last: 1'b0,
						stream_done: 1'b0, incomplete_tail: 1'b0,
						symbols_so_far: stream_count};
					symbols_due.push_back(r);
					made++;
					walk_pos = '0;
				end
			end
			if (w.eos) begin
				r = '{symbol: '0, symbol_valid: 1'b0, last: 1'b0, stream_done: 1'b1,
					incomplete_tail: (walk_pos != 0), symbols_so_far: stream_count};
				symbols_due.push_back(r);
				made++;
				walk_pos     = '0;
				stream_count = '0;
			end
			if (made > 0)
				symbols_due[symbols_due.size() - 1].last = 1'b1;
		endfunction

		task report(string what, longint got_v, longint exp_v);
			mismatches++;
			$display("%0t ns: result word %0d: %s got %0h, expected %0h",
				$time, words_checked, what, got_v, exp_v);
		endtask

		task check_word(hbd_pkg::result_t got);
			hbd_pkg::result_t exp;
			if (symbols_due.size() == 0) begin
				report("word with nothing outstanding, symbol", got.symbol, 0);
				words_checked++;
				return;
			end
			exp = symbols_due.pop_front();
			if (got.symbol != exp.symbol)
				report("symbol", got.symbol, exp.symbol);
			if (got.symbol_valid != exp.symbol_valid)
				report("symbol_valid", got.symbol_valid, exp.symbol_valid);
			if (got.last != exp.last)
				report("last", got.last, exp.last);
			if (got.stream_done != exp.stream_done)
				report("stream_done", got.stream_done, exp.stream_done);
			if (got.incomplete_tail != exp.incomplete_tail)
				report("incomplete_tail", got.incomplete_tail, exp.incomplete_tail);
			if (got.symbols_so_far != exp.symbols_so_far)
				report("symbols_so_far", got.symbols_so_far, exp.symbols_so_far);
			words_checked++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// From bit 0: node_index[9], zero_child[9], one_child[9], node_is_leaf,
	// node_symbol[8], data_byte[8], valid_bits[4].
	logic [47:0] s_axis_tdata;
	// Bit 0: opcode.
	logic        s_axis_tuser;
	// end_of_stream.
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// From bit 0: symbol[8], incomplete_tail, symbols_so_far[24], zero padding.
	logic [39:0] m_axis_tdata;
	// From bit 0: symbol_valid, stream_done.
	logic [1:0]  m_axis_tuser;
	// last.
	logic        m_axis_tlast;

	symbol_scoreboard sb;

	// Slots that hold a node. Every written node points only at written slots,
	// so no walk can ever read a slot that was never loaded.
	bit          slot_written [hbd_pkg::TREE_NODES];
	int          written_slots [$];

	int          loads_sent;
	int          bytes_sent;
	int          streams_closed;
	int          results_taken;
	int          quiet_cycles;
	int          symbols_seen;
	bit          sender_burst;
	bit          receiver_burst;

	huffman_tree_bit_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offers one word after a random gap (none in burst stretches), then holds
	// it until the block takes it. Called just after a rising edge, so every
	// change lands on a falling edge.
	task send_word(dec_word_t w);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {w.nbits, w.dbyte, w.sym, w.leaf, w.oc, w.zc, w.idx};
		s_axis_tuser  <= w.op;
		s_axis_tlast  <= w.eos;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_word(w);
	endtask

	// A node load. The data fields are don't-care here and carry random values.
	task send_load(logic [8:0] idx, logic [8:0] zc, logic [8:0] oc, logic leaf,
		logic [7:0] sym);
		dec_word_t w;
		w = '{op: hbd_pkg::OP_LOAD, idx: idx, zc: zc, oc: oc, leaf: leaf, sym: sym,
			dbyte: $urandom, nbits: $urandom, eos: $urandom};
		send_word(w);
		loads_sent++;
		if (!slot_written[idx]) begin
			slot_written[idx] = 1'b1;
			written_slots.push_back(idx);
		end
	endtask

	// A data byte. The node fields are don't-care here and carry random values.
	task send_byte(logic [7:0] dbyte, logic [3:0] nbits, logic eos);
		dec_word_t w;
		w = '{op: hbd_pkg::OP_DATA, idx: $urandom, zc: $urandom, oc: $urandom,
			leaf: $urandom, sym: $urandom, dbyte: dbyte, nbits: nbits, eos: eos};
		send_word(w);
		bytes_sent++;
		if (eos)
			streams_closed++;
	endtask

	// Builds a random full binary tree rooted at slot 0 by splitting open
	// leaves, scatters its nodes over the table and loads them in random order.
	// Any bit pattern then walks a well-formed path through it.
	task load_random_tree(int leaves);
		logic [8:0] slot [32];
		int         kid0 [32];
		int         kid1 [32];
		bit         is_leaf [32];
		bit         taken [hbd_pkg::TREE_NODES];
		int         open_q [$];
		int         order [$];
		int         n_nodes;
		int         pick;
		int         parent;
		logic [8:0] s;
		taken    = '{default: 1'b0};
		is_leaf  = '{default: 1'b0};
		taken[0] = 1'b1;
		slot[0]  = '0;
		n_nodes  = 1;
		open_q   = {0};
		repeat (leaves - 1) begin
			pick   = $urandom_range(0, open_q.size() - 1);
			parent = open_q[pick];
			open_q.delete(pick);
			for (int k = 0; k < 2; k++) begin
				do
					s = $urandom_range(1, hbd_pkg::TREE_NODES - 1);
				while (taken[s]);
				taken[s]      = 1'b1;
				slot[n_nodes] = s;
				if (k == 0)
					kid0[parent] = n_nodes;
				else
					kid1[parent] = n_nodes;
				open_q.push_back(n_nodes);
				n_nodes++;
			end
		end
		foreach (open_q[i])
			is_leaf[open_q[i]] = 1'b1;
		for (int i = 0; i < n_nodes; i++)
			order.push_back(i);
		order.shuffle();
		foreach (order[i]) begin
			if (is_leaf[order[i]]) begin
				// A leaf's children are never followed; keep them inside the tree.
				send_load(slot[order[i]], slot[$urandom_range(0, n_nodes - 1)],
					slot[$urandom_range(0, n_nodes - 1)], 1'b1, $urandom);
			end else begin
				send_load(slot[order[i]], slot[kid0[order[i]]], slot[kid1[order[i]]],
					1'b0, $urandom);
			end
		end
	endtask

	// Overwrites any slot, the root included, with children taken from the
	// written slots. It may break the current tree but never opens a path to
	// an unloaded slot.
	task load_noise_node();
		send_load($urandom_range(0, hbd_pkg::TREE_NODES - 1),
			written_slots[$urandom_range(0, written_slots.size() - 1)],
			written_slots[$urandom_range(0, written_slots.size() - 1)],
			($urandom_range(0, 3) == 0), $urandom);
	endtask

	// A run of data bytes, usually closed by end of stream. Now and then the
	// bit count is zero or above eight, and now and then the stream is left open.
	task send_stream(int nbytes);
		logic [3:0] nb;
		for (int i = 0; i < nbytes; i++) begin
			nb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
			send_byte($urandom, nb, (i == nbytes - 1) && ($urandom_range(0, 9) != 0));
		end
	endtask

	// Result sampling. The scoreboard is only ever handed words that the
	// block has handed over at a rising edge.
	always @(posedge clk) begin
		hbd_pkg::result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.symbol          = m_axis_tdata[7:0];
			got.incomplete_tail = m_axis_tdata[8];
			got.symbols_so_far  = m_axis_tdata[32:9];
			got.symbol_valid    = m_axis_tuser[0];
			got.stream_done     = m_axis_tuser[1];
			got.last            = m_axis_tlast;
			sb.check_word(got);
			results_taken++;
			if (got.symbol_valid)
				symbols_seen++;
		end
	end

	// Watchdog: any handshake on either port counts as progress.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("No handshake for %0d cycles, %0d result words outstanding",
					WATCHDOG_LIMIT, sb.pending());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Receiver. Before each word it drops tready for a random number of
	// cycles, except in burst stretches. Once, well into the run, it holds off
	// for a long stretch so that the output register fills and the block
	// stalls its slave port while the sender keeps offering.
	initial begin
		int  gap;
		bit  pressure_done;
		pressure_done  = 1'b0;
		receiver_burst = 1'b0;
		m_axis_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = receiver_burst ? 0 : $urandom_range(0, 4);
			if (!pressure_done && results_taken >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				gap = PRESSURE_CYCLES;
			end
			@(negedge clk);
			repeat (gap) begin
				m_axis_tready <= 1'b0;
				@(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_axis_tvalid);
			if ($urandom_range(0, 19) == 0)
				receiver_burst = !receiver_burst;
		end
	end

	initial begin
		sb             = new();
		slot_written   = '{default: 1'b0};
		loads_sent     = 0;
		bytes_sent     = 0;
		streams_closed = 0;
		results_taken  = 0;
		quiet_cycles   = 0;
		symbols_seen   = 0;
		sender_burst   = 1'b0;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = hbd_pkg::OP_LOAD;
		s_axis_tlast   = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed tree over the extreme slots: root 0, leaves 256, 1 and 510,
		// inner node 511. Codes, first bit first: 0 -> 00, 1 0 -> FF,
		// 1 1 -> A5. The root also carries a leaf mark, which must not fire
		// at the start of a walk.
		send_load(9'd0,   9'd256, 9'd511, 1'b1, 8'h00);
		send_load(9'd256, 9'd0,   9'd511, 1'b1, 8'h00);
		send_load(9'd511, 9'd1,   9'd510, 1'b0, 8'hFF);
		send_load(9'd1,   9'd511, 9'd256, 1'b1, 8'hFF);
		send_load(9'd510, 9'd0,   9'd1,   1'b1, 8'hA5);
		send_byte(8'hFF, 4'd8,  1'b0);   // four A5 symbols
		send_byte(8'h00, 4'd8,  1'b1);   // eight symbols and the status: the most words
		send_byte(8'h5A, 4'd0,  1'b0);   // no bits used at all
		send_byte(8'h01, 4'd1,  1'b0);   // stops inside a codeword
		send_byte(8'h00, 4'd0,  1'b1);   // ends there: partial tail flagged
		send_byte(8'h00, 4'd0,  1'b1);   // empty stream
		send_byte(8'h02, 4'd15, 1'b0);   // count above eight is clipped
		send_byte(8'hAA, 4'd9,  1'b1);
		send_byte(8'h03, 4'd2,  1'b0);
		send_byte(8'h01, 4'd1,  1'b1);

		// Random part: fresh trees, streams over them, and the odd stray load.
		load_random_tree($urandom_range(2, 9));
		while (loads_sent + bytes_sent < RANDOM_WORDS + 15) begin
			if ($urandom_range(0, 2) == 0)
				load_random_tree($urandom_range(2, 9));
			repeat ($urandom_range(1, 3)) begin
				sender_burst = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 9) == 0)
					load_noise_node();
				send_stream($urandom_range(1, 5));
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d node loads and %0d data bytes, %0d streams closed;",
			loads_sent, bytes_sent, streams_closed);
		$display("checked %0d result words, %0d of them symbols, %0d mismatches.",
			sb.words_checked, symbols_seen, sb.mismatches);
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
